FILE: hdl/bce_pkg.sv
// Shared types, constants and helper functions of the Bifid cipher engine.
package bce_pkg;

  localparam int MAX_PERIOD_DEF = 8;
  localparam int CELLS          = 25;
  localparam int ALPHA          = 26;
  localparam int LETTER_W       = 5;
  localparam int COORD_W        = 3;
  localparam int GLEN_W         = 4;
  localparam int TDATA_W        = 8;
  localparam int CFG_IDX_W      = 1;

  localparam logic [LETTER_W-1:0] LET_I = 5'd8;
  localparam logic [LETTER_W-1:0] LET_J = 5'd9;
  localparam logic [LETTER_W-1:0] LET_Z = 5'd25;

  localparam logic [GLEN_W-1:0] GLEN_RESET = 4'd5;
  localparam logic [LETTER_W-1:0] ROW_MUL   = 5'd13;

  localparam logic REQ_KEY = 1'b0;
  localparam logic REQ_MSG = 1'b1;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [COORD_W-1:0]  coord_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 1'b0,
    CFG_LENGTH = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic new_key;
    logic place_en;
    logic walk;
    logic buf_wr;
    logic rd_en;
    logic load_out;
    logic end_flag;
    logic msg_flag;
  } dp_cmd_t;

  function automatic letter_t norm_letter(letter_t v);
    if (v > LET_Z) return LET_Z;
    if (v == LET_J) return LET_I;
    return v;
  endfunction

  // row = p / 5 for p below 25, by reciprocal multiply
  function automatic coord_t cell_row(letter_t p);
    logic [2*LETTER_W-1:0] prod;
    prod = {{LETTER_W{1'b0}}, p} * {{LETTER_W{1'b0}}, ROW_MUL};
    return prod[8:6];
  endfunction

  function automatic coord_t cell_col(letter_t p);
    letter_t r5;
    r5 = {2'b00, cell_row(p)} * 5'd5;
    return coord_t'(p - r5);
  endfunction

  function automatic letter_t init_square(letter_t c);
    return (c < LET_J) ? c : letter_t'(c + 5'd1);
  endfunction

  function automatic letter_t init_position(letter_t l);
    return (l < LET_J) ? l : letter_t'(l - 5'd1);
  endfunction

endpackage

FILE: hdl/bifid_cipher_engine_core.sv
// Top level of the Bifid cipher engine: configuration registers and stream ports.
// Usage:
//   Input stream carries key letters (in_tuser = 0) and message letters
//   (in_tuser = 1), letter index in in_tdata[4:0], in_tlast on the final item
//   of a key or of a message. The last key item then walks the alphabet to
//   complete the square, taking no requests meanwhile. When a message letter
//   closes a group of n letters, the results are read from the two coordinate
//   buffer copies and looked up in the square into the output register, one
//   per cycle while the output accepts them; the next request is taken once
//   all n results have moved into the output register.
//   Output stream: letter in out_tdata[4:0], out_tuser marks the last result
//   of a group, out_tlast the last result of the message.
//   A stalled output holds its result; emission of a group pauses until the
//   output register is free. Configuration (cipher mode, group length) is
//   written through cfg_we/cfg_index/cfg_wdata; the user must write it only
//   while the block is idle, the block itself does not enforce this.
//   Synchronous reset restores the alphabet square, mode encode, length 5.
module bifid_cipher_engine_core #(
  parameter int MAX_PERIOD = bce_pkg::MAX_PERIOD_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bce_pkg::TDATA_W-1:0]         in_tdata,    // [4:0] letter
  input  logic [0:0]                          in_tuser,    // [0] req_type
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bce_pkg::TDATA_W-1:0]         out_tdata,   // [4:0] out_letter
  output logic [0:0]                          out_tuser,   // [0] group_end
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [bce_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bce_pkg::GLEN_W-1:0]          cfg_wdata
);

  localparam int AW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
  localparam int CW = $clog2(MAX_PERIOD + 1);

  logic                        cipher_mode_r;
  logic [bce_pkg::GLEN_W-1:0]  group_length_r;

  bce_pkg::dp_cmd_t  cmd;
  bce_pkg::letter_t  walk_letter;
  logic [AW-1:0]     buf_addr;
  logic [CW-1:0]     grp_n;
  logic [CW-1:0]     emit_k;
  bce_pkg::letter_t  res_letter;
  logic              res_group_end;
  logic              res_message_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cipher_mode_r  <= bce_pkg::MODE_ENCODE;
      group_length_r <= bce_pkg::GLEN_RESET;
    end else if (cfg_we) begin
      unique case (bce_pkg::cfg_idx_t'(cfg_index))
        bce_pkg::CFG_MODE:   cipher_mode_r  <= cfg_wdata[0];
        bce_pkg::CFG_LENGTH: group_length_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  bce_ctrl #(.MAX_PERIOD(MAX_PERIOD)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_req_type  (in_tuser[0]),
    .in_last      (in_tlast),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .group_length (group_length_r),
    .cmd          (cmd),
    .walk_letter  (walk_letter),
    .buf_addr     (buf_addr),
    .grp_n        (grp_n),
    .emit_k       (emit_k)
  );

  bce_dp #(.MAX_PERIOD(MAX_PERIOD)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_letter       (in_tdata[bce_pkg::LETTER_W-1:0]),
    .walk_letter     (walk_letter),
    .buf_addr        (buf_addr),
    .grp_n           (grp_n),
    .emit_k          (emit_k),
    .cipher_mode     (cipher_mode_r),
    .res_letter      (res_letter),
    .res_group_end   (res_group_end),
    .res_message_end (res_message_end)
  );

  assign out_tdata = {{(bce_pkg::TDATA_W - bce_pkg::LETTER_W){1'b0}}, res_letter};
  assign out_tuser = res_group_end;
  assign out_tlast = res_message_end;

  a_msg_end_closes_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0])
    else $error("message end without group end");

  a_letter_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[bce_pkg::LETTER_W-1:0] != bce_pkg::LET_J) &&
                   (out_tdata[bce_pkg::LETTER_W-1:0] <= bce_pkg::LET_Z))
    else $error("result letter outside square alphabet");

  a_key_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == bce_pkg::REQ_KEY) && !out_tvalid
      |=> !out_tvalid)
    else $error("key request produced a result");

endmodule

FILE: hdl/bce_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bce_ram #(
  parameter int WIDTH = 2 * bce_pkg::COORD_W,
  parameter int DEPTH = bce_pkg::MAX_PERIOD_DEF
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/bce_dp.sv
// Datapath: key square, letter positions, coordinate buffers and result register.
module bce_dp #(
  parameter int MAX_PERIOD = bce_pkg::MAX_PERIOD_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  bce_pkg::dp_cmd_t                          cmd,
  input  bce_pkg::letter_t                          in_letter,
  input  bce_pkg::letter_t                          walk_letter,
  input  logic [((MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1)-1:0] buf_addr,
  input  logic [$clog2(MAX_PERIOD+1)-1:0]           grp_n,
  input  logic [$clog2(MAX_PERIOD+1)-1:0]           emit_k,
  input  logic                                      cipher_mode,
  output bce_pkg::letter_t                          res_letter,
  output logic                                      res_group_end,
  output logic                                      res_message_end
);

  localparam int AW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
  localparam int SW = $clog2(2 * MAX_PERIOD);
  localparam int EW = 2 * bce_pkg::COORD_W;

  bce_pkg::letter_t square_r [bce_pkg::CELLS];
  bce_pkg::letter_t pos_r    [bce_pkg::ALPHA];
  logic [bce_pkg::ALPHA-1:0] used_r;
  bce_pkg::letter_t key_fill_r;

  bce_pkg::letter_t letter_n;
  bce_pkg::letter_t sel_letter;
  bce_pkg::letter_t fill_eff;
  logic             used_eff;
  logic             do_place;

  bce_pkg::letter_t  msg_pos;
  logic [EW-1:0]     buf_wdata;
  logic [SW-1:0]     k_s;
  logic [SW-1:0]     n_s;
  logic [SW-1:0]     idx_a;
  logic [SW-1:0]     idx_b;
  logic [AW:0]       map_a;
  logic [AW:0]       map_b;
  logic [EW-1:0]     rd_a;
  logic [EW-1:0]     rd_b;
  logic              half_a_r;
  logic              half_b_r;
  bce_pkg::coord_t   row_c;
  bce_pkg::coord_t   col_c;
  bce_pkg::letter_t  cell_idx;

  bce_pkg::letter_t  res_letter_r;
  logic              res_group_end_r;
  logic              res_message_end_r;

  function automatic logic [AW:0] seq_map(logic [SW-1:0] idx, logic [SW-1:0] len,
                                          logic dec);
    logic [AW-1:0] addr;
    logic          half;
    if (dec) begin
      addr = AW'(idx >> 1);
      half = idx[0];
    end else if (idx < len) begin
      addr = AW'(idx);
      half = 1'b0;
    end else begin
      addr = AW'(idx - len);
      half = 1'b1;
    end
    return {addr, half};
  endfunction

  // key placement
  assign letter_n   = bce_pkg::norm_letter(in_letter);
  assign sel_letter = cmd.walk ? walk_letter : letter_n;
  assign used_eff   = cmd.new_key ? 1'b0 : used_r[sel_letter];
  assign fill_eff   = cmd.new_key ? '0 : key_fill_r;
  assign do_place   = cmd.place_en && !used_eff &&
                      (fill_eff < bce_pkg::LETTER_W'(bce_pkg::CELLS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < bce_pkg::CELLS; c++) begin
        square_r[c] <= bce_pkg::init_square(bce_pkg::LETTER_W'(c));
      end
      for (int l = 0; l < bce_pkg::ALPHA; l++) begin
        pos_r[l] <= bce_pkg::init_position(bce_pkg::LETTER_W'(l));
      end
      used_r     <= '0;
      key_fill_r <= '0;
    end else begin
      if (do_place) begin
        square_r[fill_eff]   <= sel_letter;
        pos_r[sel_letter]    <= fill_eff;
        key_fill_r           <= bce_pkg::letter_t'(fill_eff + 5'd1);
      end else if (cmd.new_key) begin
        key_fill_r <= '0;
      end
      if (cmd.new_key) begin
        used_r <= do_place ? (bce_pkg::ALPHA'(1) << sel_letter) : '0;
      end else if (do_place) begin
        used_r[sel_letter] <= 1'b1;
      end
    end
  end

  // coordinate buffers, entry = {col, row}
  assign msg_pos   = pos_r[letter_n];
  assign buf_wdata = {bce_pkg::cell_col(msg_pos), bce_pkg::cell_row(msg_pos)};

  assign k_s   = SW'(emit_k);
  assign n_s   = SW'(grp_n);
  assign idx_a = (cipher_mode == bce_pkg::MODE_DECODE) ? k_s : SW'({emit_k, 1'b0});
  assign idx_b = (cipher_mode == bce_pkg::MODE_DECODE) ? SW'(n_s + k_s)
                                                       : SW'({emit_k, 1'b1});
  assign map_a = seq_map(idx_a, n_s, cipher_mode == bce_pkg::MODE_DECODE);
  assign map_b = seq_map(idx_b, n_s, cipher_mode == bce_pkg::MODE_DECODE);

  bce_ram #(.WIDTH(EW), .DEPTH(MAX_PERIOD)) u_ram_a (
    .clk   (clk),
    .we    (cmd.buf_wr),
    .waddr (buf_addr),
    .wdata (buf_wdata),
    .re    (cmd.rd_en),
    .raddr (map_a[AW:1]),
    .rdata (rd_a)
  );

  bce_ram #(.WIDTH(EW), .DEPTH(MAX_PERIOD)) u_ram_b (
    .clk   (clk),
    .we    (cmd.buf_wr),
    .waddr (buf_addr),
    .wdata (buf_wdata),
    .re    (cmd.rd_en),
    .raddr (map_b[AW:1]),
    .rdata (rd_b)
  );

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      half_a_r <= map_a[0];
      half_b_r <= map_b[0];
    end
  end

  assign row_c    = half_a_r ? rd_a[EW-1:bce_pkg::COORD_W] : rd_a[bce_pkg::COORD_W-1:0];
  assign col_c    = half_b_r ? rd_b[EW-1:bce_pkg::COORD_W] : rd_b[bce_pkg::COORD_W-1:0];
  assign cell_idx = ({2'b00, row_c} * 5'd5) + {2'b00, col_c};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_letter_r      <= square_r[cell_idx];
      res_group_end_r   <= cmd.end_flag;
      res_message_end_r <= cmd.msg_flag;
    end
  end

  assign res_letter      = res_letter_r;
  assign res_group_end   = res_group_end_r;
  assign res_message_end = res_message_end_r;

endmodule

FILE: hdl/bce_ctrl.sv
// Controller: request sequencing, key completion walk and group emission.
module bce_ctrl #(
  parameter int MAX_PERIOD = bce_pkg::MAX_PERIOD_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  input  logic                                      in_req_type,
  input  logic                                      in_last,
  input  logic                                      out_tready,
  output logic                                      out_tvalid,
  input  logic [bce_pkg::GLEN_W-1:0]                group_length,
  output bce_pkg::dp_cmd_t                          cmd,
  output bce_pkg::letter_t                          walk_letter,
  output logic [((MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1)-1:0] buf_addr,
  output logic [$clog2(MAX_PERIOD+1)-1:0]           grp_n,
  output logic [$clog2(MAX_PERIOD+1)-1:0]           emit_k
);

  localparam int AW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
  localparam int CW = $clog2(MAX_PERIOD + 1);
  localparam int GW = (CW > bce_pkg::GLEN_W) ? CW : bce_pkg::GLEN_W;

  bce_pkg::ctrl_state_t state_r, state_nxt;
  logic                 key_open_r, key_open_nxt;
  bce_pkg::letter_t     walk_r, walk_nxt;
  logic [CW-1:0]        gc_r, gc_nxt;
  logic [CW-1:0]        n_r, n_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic                 msg_last_r, msg_last_nxt;
  logic                 pend_r, pend_nxt;
  logic                 pend_end_r, pend_end_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [CW-1:0]        period;
  logic [CW-1:0]        cnt_new;
  logic                 gc_room;
  logic                 load_out;
  logic                 issue;
  logic                 ready_c;

  always_comb begin
    if (group_length == '0) begin
      period = CW'(1);
    end else if (GW'(group_length) > GW'(MAX_PERIOD)) begin
      period = CW'(MAX_PERIOD);
    end else begin
      period = CW'(group_length);
    end
  end

  assign gc_room  = gc_r < CW'(MAX_PERIOD);
  assign cnt_new  = gc_room ? CW'(gc_r + 1'b1) : gc_r;
  assign load_out = pend_r && (!out_valid_r || out_tready);
  assign issue    = (state_r == bce_pkg::ST_EMIT) && (k_r < n_r) && (!pend_r || load_out);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bce_pkg::ST_IDLE;
      key_open_r  <= 1'b0;
      walk_r      <= '0;
      gc_r        <= '0;
      n_r         <= '0;
      k_r         <= '0;
      msg_last_r  <= 1'b0;
      pend_r      <= 1'b0;
      pend_end_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key_open_r  <= key_open_nxt;
      walk_r      <= walk_nxt;
      gc_r        <= gc_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      msg_last_r  <= msg_last_nxt;
      pend_r      <= pend_nxt;
      pend_end_r  <= pend_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    key_open_nxt  = key_open_r;
    walk_nxt      = walk_r;
    gc_nxt        = gc_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    msg_last_nxt  = msg_last_r;
    pend_nxt      = pend_r;
    pend_end_nxt  = pend_end_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    ready_c       = 1'b0;

    // result pipeline: buffer read, then square lookup into the output register
    cmd.rd_en    = issue;
    cmd.load_out = load_out;
    cmd.end_flag = pend_end_r;
    cmd.msg_flag = pend_end_r && msg_last_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (issue) begin
      pend_nxt     = 1'b1;
      pend_end_nxt = (CW'(k_r + 1'b1) == n_r);
      k_nxt        = CW'(k_r + 1'b1);
    end else if (load_out) begin
      pend_nxt = 1'b0;
    end

    unique case (state_r)
      bce_pkg::ST_IDLE: begin
        ready_c = rst_n;
        if (in_tvalid && rst_n) begin
          if (in_req_type == bce_pkg::REQ_KEY) begin
            cmd.new_key  = !key_open_r;
            cmd.place_en = 1'b1;
            key_open_nxt = 1'b1;
            if (in_last) begin
              walk_nxt  = '0;
              state_nxt = bce_pkg::ST_FILL;
            end
          end else begin
            cmd.buf_wr = gc_room;
            if (cnt_new >= period || in_last) begin
              n_nxt        = cnt_new;
              k_nxt        = '0;
              msg_last_nxt = in_last;
              gc_nxt       = '0;
              state_nxt    = bce_pkg::ST_EMIT;
            end else begin
              gc_nxt = cnt_new;
            end
          end
        end
      end
      bce_pkg::ST_FILL: begin
        cmd.walk     = 1'b1;
        cmd.place_en = (walk_r != bce_pkg::LET_J);
        if (walk_r == bce_pkg::LET_Z) begin
          key_open_nxt = 1'b0;
          state_nxt    = bce_pkg::ST_IDLE;
        end else begin
          walk_nxt = bce_pkg::letter_t'(walk_r + 5'd1);
        end
      end
      bce_pkg::ST_EMIT: begin
        if (k_r == n_r && (!pend_r || load_out)) begin
          state_nxt = bce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bce_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_tready   = ready_c;
  assign out_tvalid  = out_valid_r;
  assign walk_letter = walk_r;
  assign buf_addr    = AW'(gc_r);
  assign grp_n       = n_r;
  assign emit_k      = k_r;

endmodule
